### hw/rtl/dtmf_pkg.sv
`timescale 1ns / 1ps

package dtmf_pkg;

  localparam int unsigned IDX_W     = 17;  // phase index width, wraps here
  localparam int unsigned STEP_W    = 2;   // log2 of the phase step (4)
  localparam int unsigned ROM_AW    = 7;   // log2 of the sine table depth (128)
  localparam int unsigned POS_W     = IDX_W + STEP_W;
  localparam int unsigned FL_W      = 10;  // low-tone frequency width
  localparam int unsigned FH_W      = 11;  // high-tone frequency width
  localparam int unsigned PROD_W    = POS_W + FL_W;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned PERIOD_SH = ROM_AW - STEP_W;  // samples per high period, log2
  localparam int unsigned SMP_W     = 8;

  localparam logic [CFG_W-1:0] HIGH_PERIODS_RST = CFG_W'(64);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam logic [FH_W-1:0] HIGH_HZ [4] = '{
    FH_W'(1209), FH_W'(1336), FH_W'(1477), FH_W'(1633)
  };

  localparam logic [FL_W-1:0] LOW_HZ [4] = '{
    FL_W'(697), FL_W'(770), FL_W'(852), FL_W'(941)
  };

  localparam logic [SMP_W-1:0] SINE_ROM [2**ROM_AW] = '{
    8'd128, 8'd134, 8'd140, 8'd146, 8'd152, 8'd158, 8'd165, 8'd170,
    8'd176, 8'd182, 8'd188, 8'd193, 8'd198, 8'd203, 8'd208, 8'd213,
    8'd218, 8'd222, 8'd226, 8'd230, 8'd234, 8'd237, 8'd240, 8'd243,
    8'd245, 8'd248, 8'd250, 8'd251, 8'd253, 8'd254, 8'd254, 8'd255,
    8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd251, 8'd250, 8'd248,
    8'd245, 8'd243, 8'd240, 8'd237, 8'd234, 8'd230, 8'd226, 8'd222,
    8'd218, 8'd213, 8'd208, 8'd203, 8'd198, 8'd193, 8'd188, 8'd182,
    8'd176, 8'd170, 8'd165, 8'd158, 8'd152, 8'd146, 8'd140, 8'd134,
    8'd128, 8'd121, 8'd115, 8'd109, 8'd103, 8'd97,  8'd90,  8'd85,
    8'd79,  8'd73,  8'd67,  8'd62,  8'd57,  8'd52,  8'd47,  8'd42,
    8'd37,  8'd33,  8'd29,  8'd25,  8'd21,  8'd18,  8'd15,  8'd12,
    8'd10,  8'd7,   8'd5,   8'd4,   8'd2,   8'd1,   8'd1,   8'd0,
    8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd4,   8'd5,   8'd7,
    8'd10,  8'd12,  8'd15,  8'd18,  8'd21,  8'd25,  8'd29,  8'd33,
    8'd37,  8'd42,  8'd47,  8'd52,  8'd57,  8'd62,  8'd67,  8'd73,
    8'd79,  8'd85,  8'd90,  8'd97,  8'd103, 8'd109, 8'd115, 8'd121
  };

endpackage

### hw/rtl/dtmf_in_if.sv
`timescale 1ns / 1ps

interface dtmf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] row;
  logic [1:0] col;

  modport source (output valid, output command, output row, output col, input ready);
  modport sink   (input valid, input command, input row, input col, output ready);
endinterface

### hw/rtl/dtmf_out_if.sv
`timescale 1ns / 1ps

interface dtmf_out_if;
  logic                       valid;
  logic                       ready;
  logic [dtmf_pkg::SMP_W-1:0] sample;
  logic                       last;
  logic                       accepted;

  modport source (output valid, output sample, output last, output accepted, input ready);
  modport sink   (input valid, input sample, input last, input accepted, output ready);
endinterface

### hw/rtl/dtmf_mul.sv
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle, MSB first.
module dtmf_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dtmf_pkg::POS_W-1:0]  mcand_i,
  input  logic [dtmf_pkg::FL_W-1:0]   mplier_i,
  output logic [dtmf_pkg::PROD_W-1:0] prod_o,
  output dtmf_pkg::unit_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(dtmf_pkg::FL_W + 1);

  logic [dtmf_pkg::PROD_W-1:0] acc_q, acc_d;
  logic [dtmf_pkg::POS_W-1:0]  mcand_q;
  logic [dtmf_pkg::FL_W-1:0]   mpl_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;

  always_comb begin
    acc_d = {acc_q[dtmf_pkg::PROD_W-2:0], 1'b0};
    if (mpl_q[dtmf_pkg::FL_W-1]) begin
      acc_d = acc_d + dtmf_pkg::PROD_W'(mcand_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      mcand_q <= '0;
      mpl_q   <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        acc_q   <= '0;
        mcand_q <= mcand_i;
        mpl_q   <= mplier_i;
        cnt_q   <= '0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_d;
        mpl_q <= {mpl_q[dtmf_pkg::FL_W-2:0], 1'b0};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(dtmf_pkg::FL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### hw/rtl/dtmf_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Only the low quotient bits
// that address the sine table are kept, plus a nonzero-remainder flag.
module dtmf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dtmf_pkg::PROD_W-1:0] dividend_i,
  input  logic [dtmf_pkg::FH_W-1:0]   divisor_i,
  output logic [dtmf_pkg::ROM_AW-1:0] quot_o,
  output logic                        rem_nz_o,
  output dtmf_pkg::unit_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(dtmf_pkg::PROD_W);

  logic [dtmf_pkg::PROD_W-1:0] dvd_q;
  logic [dtmf_pkg::FH_W-1:0]   dvs_q;
  logic [dtmf_pkg::FH_W-1:0]   rem_q, rem_d;
  logic [dtmf_pkg::ROM_AW-1:0] quot_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;
  logic [dtmf_pkg::FH_W:0]     trial;
  logic                        ge;

  always_comb begin
    trial = {rem_q, dvd_q[dtmf_pkg::PROD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? dtmf_pkg::FH_W'(trial - {1'b0, dvs_q}) : trial[dtmf_pkg::FH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        quot_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q  <= {dvd_q[dtmf_pkg::PROD_W-2:0], 1'b0};
        rem_q  <= rem_d;
        quot_q <= {quot_q[dtmf_pkg::ROM_AW-2:0], ge};
        cnt_q  <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(dtmf_pkg::PROD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o      = quot_q;
  assign rem_nz_o    = |rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### hw/rtl/dtmf_tone_sample_generator.sv
`timescale 1ns / 1ps

// DTMF tone sample generator. A start transfer (command 1) latches row and
// column, unless a tone is playing, and moves to ST_RESULT, where one result
// with accepted telling whether the tone started is registered once the
// output register is free; the input is ready again after that. A tick
// transfer (command 0) while a tone plays returns one 8-bit sample: the
// bit-serial multiplier forms index*4*f_low, the product is handed to the
// restoring divider, which divides it by f_high one quotient bit per cycle,
// and in ST_RESULT the table entries are picked and the result is registered
// once the output register is free. The input is ready again after that, so
// a result still held in the output register stalls the next one in
// ST_RESULT. A tick while idle is dropped without a result. The input is
// taken only while no item is in work; a finished result waits in the output
// register without blocking the next transfer. The sample after which the
// index reaches high_periods*32 or more is flagged last and the tone then
// stops.
module dtmf_tone_sample_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dtmf_pkg::CFG_W-1:0] cfg_data_i,
  dtmf_in_if.sink                    in_i,
  dtmf_out_if.source                 out_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_RESULT} state_e;

  state_e                       state_q;
  logic [dtmf_pkg::CFG_W-1:0]   high_periods_q;
  logic [dtmf_pkg::IDX_W-1:0]   idx_q;
  logic                         active_q;
  logic [1:0]                   high_sel_q, low_sel_q;
  logic                         pend_start_q, pend_ok_q;
  logic                         out_valid_q, out_last_q, out_acc_q;
  logic [dtmf_pkg::SMP_W-1:0]   out_sample_q;

  logic                         in_xfer, out_xfer, mul_start, load;
  logic [dtmf_pkg::PROD_W-1:0]  prod;
  logic [dtmf_pkg::ROM_AW-1:0]  quot, quot_up, hi_addr;
  logic                         rem_nz;
  dtmf_pkg::unit_stat_t         mul_stat, div_stat;
  logic [dtmf_pkg::SMP_W:0]     low_sum, mix_sum;
  logic [dtmf_pkg::IDX_W-1:0]   idx_next, limit;
  logic                         fin;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;
  assign mul_start  = in_xfer && !in_i.command && active_q;
  assign load       = (state_q == ST_RESULT) && (!out_valid_q || out_o.ready);

  dtmf_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  ({idx_q, dtmf_pkg::STEP_W'(0)}),
    .mplier_i (dtmf_pkg::LOW_HZ[low_sel_q]),
    .prod_o   (prod),
    .stat_o   (mul_stat)
  );

  dtmf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_stat.done),
    .dividend_i (prod),
    .divisor_i  (dtmf_pkg::HIGH_HZ[high_sel_q]),
    .quot_o     (quot),
    .rem_nz_o   (rem_nz),
    .stat_o     (div_stat)
  );

  // Floor and ceiling of the low-tone phase, wrapped to the table.
  assign quot_up = quot + dtmf_pkg::ROM_AW'(rem_nz);
  assign hi_addr = {idx_q[dtmf_pkg::PERIOD_SH-1:0], dtmf_pkg::STEP_W'(0)};

  always_comb begin
    low_sum = {1'b0, dtmf_pkg::SINE_ROM[quot]} + {1'b0, dtmf_pkg::SINE_ROM[quot_up]};
    mix_sum = {1'b0, dtmf_pkg::SINE_ROM[hi_addr]} + {1'b0, low_sum[dtmf_pkg::SMP_W:1]};
  end

  assign idx_next = idx_q + dtmf_pkg::IDX_W'(1);
  assign limit    = dtmf_pkg::IDX_W'({high_periods_q, dtmf_pkg::PERIOD_SH'(0)});
  assign fin      = idx_next >= limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      high_periods_q <= dtmf_pkg::HIGH_PERIODS_RST;
      idx_q          <= '0;
      active_q       <= 1'b0;
      high_sel_q     <= '0;
      low_sel_q      <= '0;
      pend_start_q   <= 1'b0;
      pend_ok_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      out_sample_q   <= '0;
      out_last_q     <= 1'b0;
      out_acc_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        high_periods_q <= cfg_data_i;
      end
      if (out_xfer && !load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && in_i.command) begin
            pend_start_q <= 1'b1;
            pend_ok_q    <= !active_q;
            if (!active_q) begin
              low_sel_q  <= in_i.row;
              high_sel_q <= in_i.col;
              idx_q      <= '0;
              active_q   <= 1'b1;
            end
            state_q <= ST_RESULT;
          end else if (mul_start) begin
            pend_start_q <= 1'b0;
            state_q      <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            if (pend_start_q) begin
              out_sample_q <= '0;
              out_last_q   <= 1'b0;
              out_acc_q    <= pend_ok_q;
            end else begin
              out_sample_q <= mix_sum[dtmf_pkg::SMP_W:1];
              out_last_q   <= fin;
              out_acc_q    <= 1'b0;
              idx_q        <= idx_next;
              if (fin) begin
                active_q <= 1'b0;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.sample   = out_sample_q;
  assign out_o.last     = out_last_q;
  assign out_o.accepted = out_acc_q;

  a_units_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.command && !active_q) |=> (active_q && idx_q == '0))
    else $error("accepted start did not arm the tone");

  a_last_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !pend_start_q && fin) |=> !active_q)
    else $error("tone still active after last sample");

  a_start_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_acc_q) |-> (out_sample_q == '0 && !out_last_q))
    else $error("start result carries sample data");

endmodule

### verif/tb_dtmf_tone_sample_generator.sv
`timescale 1ns / 1ps

module tb_dtmf_tone_sample_generator;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam int unsigned RANDOM_ITEMS   = 650;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  localparam int unsigned HIGH_FREQ [4] = '{1209, 1336, 1477, 1633};
  localparam int unsigned LOW_FREQ  [4] = '{697, 770, 852, 941};

  localparam logic [7:0] WAVE [128] = '{
    8'd128, 8'd134, 8'd140, 8'd146, 8'd152, 8'd158, 8'd165, 8'd170,
    8'd176, 8'd182, 8'd188, 8'd193, 8'd198, 8'd203, 8'd208, 8'd213,
    8'd218, 8'd222, 8'd226, 8'd230, 8'd234, 8'd237, 8'd240, 8'd243,
    8'd245, 8'd248, 8'd250, 8'd251, 8'd253, 8'd254, 8'd254, 8'd255,
    8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd251, 8'd250, 8'd248,
    8'd245, 8'd243, 8'd240, 8'd237, 8'd234, 8'd230, 8'd226, 8'd222,
    8'd218, 8'd213, 8'd208, 8'd203, 8'd198, 8'd193, 8'd188, 8'd182,
    8'd176, 8'd170, 8'd165, 8'd158, 8'd152, 8'd146, 8'd140, 8'd134,
    8'd128, 8'd121, 8'd115, 8'd109, 8'd103, 8'd97,  8'd90,  8'd85,
    8'd79,  8'd73,  8'd67,  8'd62,  8'd57,  8'd52,  8'd47,  8'd42,
    8'd37,  8'd33,  8'd29,  8'd25,  8'd21,  8'd18,  8'd15,  8'd12,
    8'd10,  8'd7,   8'd5,   8'd4,   8'd2,   8'd1,   8'd1,   8'd0,
    8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd4,   8'd5,   8'd7,
    8'd10,  8'd12,  8'd15,  8'd18,  8'd21,  8'd25,  8'd29,  8'd33,
    8'd37,  8'd42,  8'd47,  8'd52,  8'd57,  8'd62,  8'd67,  8'd73,
    8'd79,  8'd85,  8'd90,  8'd97,  8'd103, 8'd109, 8'd115, 8'd121
  };

  typedef struct packed {
    logic [dtmf_pkg::SMP_W-1:0] sample;
    logic                       last;
    logic                       accepted;
  } tone_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [dtmf_pkg::CFG_W-1:0] cfg_data_i;

  dtmf_in_if  in_if ();
  dtmf_out_if out_if ();

  dtmf_tone_sample_generator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // tone state tracked alongside the block
  logic [dtmf_pkg::CFG_W-1:0] tone_len;
  logic [16:0]                phase;
  logic                       playing;
  logic [1:0]                 hi_sel;
  logic [1:0]                 lo_sel;

  tone_result_t expected_samples [$];
  tone_result_t head;
  int unsigned  errors;
  int unsigned  quiet_cycles;
  bit           calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic advance_tone(input logic cmd, input logic [1:0] r, input logic [1:0] c);
    tone_result_t    res;
    longint unsigned pos;
    longint unsigned prod;
    longint unsigned fh;
    longint unsigned q_lo;
    longint unsigned q_hi;
    int unsigned     low_mean;
    int unsigned     mix;
    res = '0;
    if (cmd == CMD_START) begin
      if (!playing) begin
        lo_sel  = r;
        hi_sel  = c;
        phase   = '0;
        playing = 1'b1;
        res.accepted = 1'b1;
      end
      expected_samples.push_back(res);
    end else if (playing) begin
      fh   = HIGH_FREQ[hi_sel];
      pos  = longint'(phase) * 4;
      prod = pos * LOW_FREQ[lo_sel];
      q_lo = prod / fh;
      q_hi = (prod + fh - 1) / fh;
      low_mean = (int'(WAVE[7'(q_lo)]) + int'(WAVE[7'(q_hi)])) >> 1;
      mix      = (int'(WAVE[7'(pos)]) + low_mean) >> 1;
      res.sample = mix[7:0];
      phase = phase + 1'b1;
      // threshold is tone_len * 32 and always fits the index width
      if (phase >= {tone_len, 5'b0}) begin
        res.last = 1'b1;
        playing  = 1'b0;
      end
      expected_samples.push_back(res);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      tone_len = cfg_data_i;
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      advance_tone(in_if.command, in_if.row, in_if.col);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected transfer sample=%0d last=%0b accepted=%0b", $time,
                 out_if.sample, out_if.last, out_if.accepted);
        errors++;
      end else begin
        head = expected_samples.pop_front();
        if (out_if.sample !== head.sample) begin
          $display("%0t: sample expected %0d actual %0d", $time, head.sample, out_if.sample);
          errors++;
        end
        if (out_if.last !== head.last) begin
          $display("%0t: last expected %0b actual %0b", $time, head.last, out_if.last);
          errors++;
        end
        if (out_if.accepted !== head.accepted) begin
          $display("%0t: accepted expected %0b actual %0b", $time, head.accepted,
                   out_if.accepted);
          errors++;
        end
      end
    end
  end

  // output back-pressure in random bursts
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("dtmf_tone_sample_generator verification failed");
      $finish;
    end
  end

  // leaves valid high after the transfer; wait_quiet or a random gap drops it
  task automatic send_item(input logic cmd, input logic [1:0] r, input logic [1:0] c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.row     <= r;
    in_if.col     <= c;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic tick_n(input int unsigned n);
    repeat (n) send_item(CMD_TICK, 2'($urandom), 2'($urandom));
  endtask

  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    // extra margin after the queue empties; a dropped tick starts no work
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [dtmf_pkg::CFG_W-1:0] len);
    wait_quiet();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // reset length of 64, idle tick, refused start, then cut short by length 0
  task automatic test_reset_length();
    send_item(CMD_TICK, 2'd3, 2'd3);
    send_item(CMD_START, 2'd0, 2'd0);
    send_item(CMD_START, 2'd3, 2'd3);
    tick_n(3);
    set_length('0);
    tick_n(1);
  endtask

  // zero length: first sample is the last one
  task automatic test_zero_length();
    send_item(CMD_START, 2'd3, 2'd3);
    tick_n(1);
    send_item(CMD_START, 2'd1, 2'd2);
    tick_n(1);
    send_item(CMD_START, 2'd2, 2'd1);
    tick_n(2);
  endtask

  // length rewritten while a tone plays
  task automatic test_length_change();
    set_length('1);
    send_item(CMD_START, 2'd3, 2'd0);
    tick_n(4);
    set_length(12'd1);
    tick_n(2);
    set_length('0);
    tick_n(1);
  endtask

  task automatic test_random_tones();
    int unsigned                sent;
    int unsigned                setting;
    int unsigned                n;
    logic [dtmf_pkg::CFG_W-1:0] len;
    sent    = 0;
    setting = 0;
    while (sent < RANDOM_ITEMS) begin
      case (setting % 8)
        0, 5, 7: len = 12'd1;
        1, 6:    len = 12'd2;
        2:       len = 12'($urandom_range(4, 4095));
        3:       len = '0;
        default: len = 12'd3;
      endcase
      setting++;
      if (sent + 120 >= RANDOM_ITEMS) begin
        calm = 1'b1;
      end
      set_length(len);
      repeat (3) begin
        if (sent < RANDOM_ITEMS) begin
          send_item(CMD_START, 2'($urandom), 2'($urandom));
          sent++;
          n = (len == 0) ? 1 : 32 * len;
          if (n > 100) begin
            n = $urandom_range(20, 60);
          end
          // cut some tones short, run others past their end
          if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, n);
          end else if ($urandom_range(0, 3) == 0) begin
            n = n + $urandom_range(1, 3);
          end
          repeat (n) begin
            if ($urandom_range(0, 19) == 0) begin
              send_item(CMD_START, 2'($urandom), 2'($urandom));
            end else begin
              send_item(CMD_TICK, 2'($urandom), 2'($urandom));
            end
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    errors       = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    tone_len     = 12'd64;
    phase        = '0;
    playing      = 1'b0;
    hi_sel       = '0;
    lo_sel       = '0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.command <= CMD_TICK;
    in_if.row     <= '0;
    in_if.col     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_length();
    test_zero_length();
    test_length_change();
    test_random_tones();
    wait_quiet();
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("dtmf_tone_sample_generator verification clean");
    end else begin
      $display("dtmf_tone_sample_generator verification failed");
    end
    $finish;
  end

endmodule
